>>> hw/rtl/ipd_pkg.sv
// Shared types and constants for the +IPD payload deframer.
package ipd_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int CFG_BITS    = 16;
   // room for length*10 + digit before the limit compare
   localparam int ACC_BITS    = ((LENGTH_BITS > CFG_BITS) ? LENGTH_BITS : CFG_BITS) + 4;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_I     = 8'h49;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_D     = 8'h44;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] IDLE_BYTE  = 8'hFF;

   localparam logic [CFG_BITS-1:0] LIMIT_RESET = CFG_BITS'(2048);

   typedef enum logic [6:0] {
      PH_WAIT_PLUS  = 7'b0000001,
      PH_WAIT_I     = 7'b0000010,
      PH_WAIT_P     = 7'b0000100,
      PH_WAIT_D     = 7'b0001000,
      PH_WAIT_COMMA = 7'b0010000,
      PH_READ_LEN   = 7'b0100000,
      PH_READ_DATA  = 7'b1000000
   } ipd_phase_type;

   typedef struct packed {
      logic       vld;
      logic [7:0] data;
      logic       last;
      logic       err;
   } ipd_result_type;

endpackage

>>> hw/rtl/ipd_payload_deframer_top.sv
// Top level of the +IPD payload deframer: input register, parser, result register.
// Usage:
//   req_ channel carries the modem receive stream, one byte per transaction;
//   byte 0xFF is an idle filler and is dropped. The block looks for "+IPD,",
//   reads a decimal length up to ':' and then forwards that many payload bytes
//   on the rsp_ channel, flagging the final one with rsp_last_of_packet.
//   A missing comma, a bad length character or a length above the limit
//   produces one transaction with rsp_format_error set and payload zero.
//   csr_wr_en/csr_wr_data write the length limit (reset value 2048); write it
//   only while no bytes are in flight.
// Timing:
//   A byte accepted into the input register is parsed combinationally when it
//   advances, and its result is captured and presented by the result register.
//   Throughput is one byte per cycle while rsp_ready is high, set by the
//   combinational parser step between the input and result registers.
// Reset clears the parser to hunting for '+', drops any held byte and result.
// When the receiver stalls, the result register holds; one more byte is taken
// into the input register, then req_ready falls until the result is taken.
module ipd_payload_deframer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_payload_byte,
   output logic                          rsp_last_of_packet,
   output logic                          rsp_format_error,
   input  logic                          csr_wr_en,
   input  logic [ipd_pkg::CFG_BITS-1:0]  csr_wr_data
);
   import ipd_pkg::*;

   logic                  in_vld_ff, in_vld_in;
   logic [7:0]            in_byte_ff;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [7:0]            rsp_data_ff;
   logic                  rsp_last_ff;
   logic                  rsp_err_ff;
   logic [CFG_BITS-1:0]   limit_ff;
   logic                  adv;
   logic                  req_acc;
   ipd_result_type        res;

   assign adv       = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || adv;
   assign req_acc   = req_valid && req_ready;
   assign in_vld_in = req_acc || (in_vld_ff && !adv);
   assign rsp_vld_in = adv ? res.vld : (rsp_vld_ff && !rsp_ready);

   ipd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (adv),
      .rx_byte      (in_byte_ff),
      .length_limit (limit_ff),
      .result       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         limit_ff   <= LIMIT_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_byte_ff <= req_rx_byte;
      end
      if (adv && res.vld) begin
         rsp_data_ff <= res.data;
         rsp_last_ff <= res.last;
         rsp_err_ff  <= res.err;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_payload_byte   = rsp_data_ff;
   assign rsp_last_of_packet = rsp_last_ff;
   assign rsp_format_error   = rsp_err_ff;

   // held byte must not be lost or altered while the result side is blocked
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !adv) |=> (in_vld_ff && $stable(in_byte_ff)))
      else $error("input byte dropped or changed while stalled");

   a_in_load: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> in_vld_ff)
      else $error("accepted transaction not held in input register");

   a_res_load: assert property (@(posedge clock) disable iff (reset)
      (adv && res.vld) |=> rsp_vld_ff)
      else $error("parser result not captured");

   a_err_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_err_ff) |-> (!rsp_last_ff && (rsp_data_ff == 8'h00)))
      else $error("error transaction carries data or last flag");

endmodule

>>> hw/rtl/ipd_parser.sv
// Header/length parser: phase and remaining-length state, one byte per step.
module ipd_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [7:0]                    rx_byte,
   input  logic [ipd_pkg::CFG_BITS-1:0]  length_limit,
   output ipd_pkg::ipd_result_type       result
);
   import ipd_pkg::*;

   ipd_phase_type            phase_ff, phase_in;
   logic [LENGTH_BITS-1:0]   rem_ff, rem_in;
   logic [LENGTH_BITS-1:0]   rem_dec;
   logic [ACC_BITS-1:0]      rem_ext, acc_sum, lim_ext, cap_ext, eff_lim;
   logic [3:0]               digit_raw;
   logic                     is_digit;

   assign rem_ext   = ACC_BITS'(rem_ff);
   assign digit_raw = 4'(rx_byte - CHAR_ZERO);
   assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign acc_sum   = (rem_ext << 3) + (rem_ext << 1) + ACC_BITS'(digit_raw);
   assign lim_ext   = ACC_BITS'(length_limit);
   assign cap_ext   = ACC_BITS'({LENGTH_BITS{1'b1}});
   assign eff_lim   = (lim_ext > cap_ext) ? cap_ext : lim_ext;
   assign rem_dec   = (rem_ff != '0) ? rem_ff - LENGTH_BITS'(1) : '0;

   always_comb begin
      phase_in = phase_ff;
      rem_in   = rem_ff;
      result   = '0;
      if (step && (rx_byte != IDLE_BYTE)) begin
         unique case (phase_ff)
            PH_WAIT_I: begin
               phase_in = (rx_byte == CHAR_I) ? PH_WAIT_P : PH_WAIT_PLUS;
            end
            PH_WAIT_P: begin
               phase_in = (rx_byte == CHAR_P) ? PH_WAIT_D : PH_WAIT_PLUS;
            end
            PH_WAIT_D: begin
               phase_in = (rx_byte == CHAR_D) ? PH_WAIT_COMMA : PH_WAIT_PLUS;
            end
            PH_WAIT_COMMA: begin
               rem_in = '0;
               if (rx_byte == CHAR_COMMA) begin
                  phase_in = PH_READ_LEN;
               end else begin
                  result.vld = 1'b1;
                  result.err = 1'b1;
                  phase_in   = PH_WAIT_PLUS;
               end
            end
            PH_READ_LEN: begin
               if (is_digit) begin
                  if (acc_sum > eff_lim) begin
                     result.vld = 1'b1;
                     result.err = 1'b1;
                     phase_in   = PH_WAIT_PLUS;
                     rem_in     = '0;
                  end else begin
                     rem_in = acc_sum[LENGTH_BITS-1:0];
                  end
               end else if (rx_byte == CHAR_COLON) begin
                  // empty packet closes straight away
                  phase_in = (rem_ff == '0) ? PH_WAIT_PLUS : PH_READ_DATA;
               end else begin
                  result.vld = 1'b1;
                  result.err = 1'b1;
                  phase_in   = PH_WAIT_PLUS;
                  rem_in     = '0;
               end
            end
            PH_READ_DATA: begin
               result.vld  = 1'b1;
               result.data = rx_byte;
               result.last = (rem_dec == '0);
               rem_in      = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = PH_WAIT_PLUS;
               end
            end
            default: begin
               // waiting for '+', also recovers from any stray code
               phase_in = (rx_byte == CHAR_PLUS) ? PH_WAIT_I : PH_WAIT_PLUS;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT_PLUS;
         rem_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
      end
   end

endmodule
